// File: rtl/skinned_vertex_bounding_box_assert.svh
// Assertion macros used by the skinned vertex bounding box back end.
`ifndef SKINNED_VERTEX_BOUNDING_BOX_ASSERT_SVH
`define SKINNED_VERTEX_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVBB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/svbb_pkg.sv
// Shared types and constants of the skinned vertex bounding box.
package svbb_pkg;

	localparam int COORD_W  = 32;
	localparam int WEIGHT_W = 17;
	localparam int WIDX_W   = 12;
	localparam int CFG_W    = 3;
	localparam int SLOT_W   = 8;
	localparam int NINF     = 4;

	localparam logic [CFG_W-1:0] INFLUENCES_RESET = 3'd4;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_VERTEX = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_VERTEX,
		KIND_CLEAR,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t                                  kind;
		logic signed [COORD_W-1:0]              pos_x;
		logic signed [COORD_W-1:0]              pos_y;
		logic signed [COORD_W-1:0]              pos_z;
		logic [NINF-1:0][SLOT_W-1:0]            slots;
		logic [NINF-1:0][WEIGHT_W-1:0]          weights;
		logic [1:0]                             last_inf;
		logic [WIDX_W-1:0]                      word_index;
		logic signed [COORD_W-1:0]              word_value;
	} job_t;

endpackage

// File: rtl/svbb_if.sv
// Channel interfaces of the skinned vertex bounding box.
interface svbb_in_if;
	import svbb_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [31:0]               bone_indices;
	logic [WEIGHT_W-1:0]       weight_0;
	logic [WEIGHT_W-1:0]       weight_1;
	logic [WEIGHT_W-1:0]       weight_2;
	logic [WEIGHT_W-1:0]       weight_3;
	logic [WIDX_W-1:0]         matrix_word_index;
	logic signed [COORD_W-1:0] matrix_word_value;
	modport source (output valid, command, pos_x, pos_y, pos_z, bone_indices,
		weight_0, weight_1, weight_2, weight_3, matrix_word_index,
		matrix_word_value, input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, bone_indices,
		weight_0, weight_1, weight_2, weight_3, matrix_word_index,
		matrix_word_value, output ready);
endinterface

interface svbb_out_if;
	import svbb_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] box_min_x;
	logic signed [COORD_W-1:0] box_min_y;
	logic signed [COORD_W-1:0] box_min_z;
	logic signed [COORD_W-1:0] box_max_x;
	logic signed [COORD_W-1:0] box_max_y;
	logic signed [COORD_W-1:0] box_max_z;
	logic                      box_empty;
	logic                      divide_fault;
	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x,
		box_max_y, box_max_z, box_empty, divide_fault, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x,
		box_max_y, box_max_z, box_empty, divide_fault, output ready);
endinterface

interface svbb_cfg_if;
	import svbb_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/svbb_front.sv
// Front end: influence register, command decode and weight masking.
module svbb_front #(
	parameter int MAX_BONES      = 256,
	parameter int MAX_INFLUENCES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	svbb_in_if.sink       items,
	svbb_cfg_if.sink      cfg,
	output logic          push_valid,
	input  logic          push_ready,
	output svbb_pkg::job_t push_data
);
	import svbb_pkg::*;

	logic [CFG_W-1:0] influences_q;
	logic [CFG_W-1:0] n_eff;

	// Hold the influence count; always take a configuration transfer
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			influences_q <= INFLUENCES_RESET;
		end else if (cfg.valid) begin
			influences_q <= cfg.data;
		end
	end

	// Clamp the count to the supported range
	always_comb begin
		if (influences_q == '0) begin
			n_eff = 3'd1;
		end else if (influences_q > 3'(MAX_INFLUENCES)) begin
			n_eff = 3'(MAX_INFLUENCES);
		end else begin
			n_eff = influences_q;
		end
	end

	assign push_valid  = items.valid;
	assign items.ready = push_ready;

	// Classify the item and drop influences of slots beyond the store
	always_comb begin
		push_data            = '0;
		push_data.pos_x      = items.pos_x;
		push_data.pos_y      = items.pos_y;
		push_data.pos_z      = items.pos_z;
		push_data.word_index = items.matrix_word_index;
		push_data.word_value = items.matrix_word_value;
		push_data.last_inf   = 2'(n_eff - 3'd1);
		for (int k = 0; k < NINF; k++) begin
			push_data.slots[k] = items.bone_indices[8*k +: 8];
		end
		push_data.weights[0] = items.weight_0;
		push_data.weights[1] = items.weight_1;
		push_data.weights[2] = items.weight_2;
		push_data.weights[3] = items.weight_3;
		for (int k = 0; k < NINF; k++) begin
			if ({1'b0, push_data.slots[k]} >= 9'(MAX_BONES)) begin
				push_data.weights[k] = '0;
			end
		end
		unique case (cmd_t'(items.command))
			CMD_LOAD:   push_data.kind = KIND_LOAD;
			CMD_VERTEX: push_data.kind = KIND_VERTEX;
			CMD_CLEAR:  push_data.kind = KIND_CLEAR;
			default:    push_data.kind = KIND_NOP;
		endcase
	end

endmodule

// File: rtl/svbb_queue.sv
// Two-entry queue between the front end and the back end.
module svbb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  svbb_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output svbb_pkg::job_t pop_data
);
	import svbb_pkg::*;

	localparam int DEPTH = 2;

	job_t       slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push_fire;
	logic       pop_fire;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Store an entry on each push transfer
	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push_fire) wr_ptr_q <= ~wr_ptr_q;
			if (pop_fire)  rd_ptr_q <= ~rd_ptr_q;
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 2'd1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/svbb_back.sv
// Back end: matrix store, blend, transform, divide and running box.
module svbb_back #(
	parameter int MAX_BONES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  svbb_pkg::job_t job,
	svbb_out_if.source     boxes
);
	import svbb_pkg::*;
	`include "skinned_vertex_bounding_box_assert.svh"

	localparam int WORDS  = MAX_BONES * 16;
	localparam int ADDR_W = $clog2(WORDS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_BLEND = 6'b000010,
		ST_XFORM = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_BOX   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic                valid;
		logic                first;
		logic                last;
		logic [3:0]          elem;
		logic [WEIGHT_W-1:0] weight;
	} btag_t;

	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		if (v > 36'sh0_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -36'sh0_8000_0000) begin
			return -32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [57:0] abs58(input logic signed [57:0] v);
		return v[57] ? 58'(-v) : v;
	endfunction

	state_t state_q;
	job_t   job_q;
	logic   pop_fire;

	logic signed [31:0] store [WORDS];

	// blend pipeline
	logic               issue_on_q;
	logic [3:0]         ie_q;
	logic [1:0]         ik_q;
	logic [11:0]        raddr;
	logic signed [31:0] rd_s1;
	btag_t              tag_s1;
	btag_t              tag_s2;
	logic signed [49:0] prod_s2;
	logic signed [51:0] acc_q;
	logic signed [51:0] acc_new;
	logic signed [51:0] acc_rnd;
	logic signed [31:0] blend_q [16];

	// transform pipeline
	logic               x_on_q;
	logic [1:0]         xr_q;
	logic [1:0]         xc_q;
	logic               xv_s1;
	logic [1:0]         xr_s1;
	logic [1:0]         xc_s1;
	logic signed [31:0] coord;
	logic signed [63:0] mul_s1;
	logic signed [55:0] term;
	logic signed [57:0] tacc_q;
	logic signed [57:0] tsum;
	logic signed [57:0] t_q [4];

	// divider
	logic [1:0]         dr_q;
	logic               div_busy_q;
	logic [4:0]         cnt_q;
	logic [57:0]        rem_q;
	logic [30:0]        low_q;
	logic [30:0]        quo_q;
	logic [57:0]        a_abs;
	logic [57:0]        d_abs;
	logic               neg;
	logic               ovf;
	logic [58:0]        rem2;
	logic               qbit;
	logic [30:0]        quo_next;
	logic               div_start;
	logic               div_done;
	logic signed [31:0] q_q [3];

	// box and result
	logic               holds_q;
	logic signed [31:0] min_q [3];
	logic signed [31:0] max_q [3];
	logic               fault_q;
	logic               out_valid_q;
	logic               emit_fire;
	logic signed [31:0] out_min_q [3];
	logic signed [31:0] out_max_q [3];
	logic               out_empty_q;
	logic               out_fault_q;

	assign job_ready = (state_q == ST_IDLE);
	assign pop_fire  = job_valid && job_ready;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || boxes.ready);

	// Matrix store: write on a load transfer, read one word per blend issue
	assign raddr = {job_q.slots[ik_q], ie_q};

	always_ff @(posedge clk) begin
		if (pop_fire && job.kind == KIND_LOAD && {1'b0, job.word_index} < 13'(WORDS)) begin
			store[job.word_index[ADDR_W-1:0]] <= job.word_value;
		end
		if (issue_on_q) begin
			rd_s1 <= store[raddr[ADDR_W-1:0]];
		end
	end

	// Blend accumulate and round
	assign acc_new = tag_s2.first ? 52'(prod_s2) : acc_q + 52'(prod_s2);
	assign acc_rnd = acc_new + 52'sd32768;

	// Transform term
	always_comb begin
		case (xc_q)
			2'd0:    coord = job_q.pos_x;
			2'd1:    coord = job_q.pos_y;
			2'd2:    coord = job_q.pos_z;
			default: coord = 32'sd65536;
		endcase
	end
	assign term = mul_s1[63:8];
	assign tsum = (xc_s1 == 2'd0 ? 58'sd0 : tacc_q) + 58'(term);

	// Divider step
	assign a_abs     = abs58(t_q[dr_q]);
	assign d_abs     = abs58(t_q[3]);
	assign neg       = t_q[dr_q][57] ^ t_q[3][57];
	assign ovf       = {15'd0, a_abs} >= {d_abs, 15'd0};
	assign rem2      = {rem_q, low_q[30]};
	assign qbit      = rem2 >= {1'b0, d_abs};
	assign quo_next  = {quo_q[29:0], qbit};
	assign div_start = (state_q == ST_DIV) && !div_busy_q && (t_q[3] != '0);
	assign div_done  = div_busy_q && (cnt_q == 5'd30);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_on_q  <= 1'b0;
			ie_q        <= '0;
			ik_q        <= '0;
			tag_s1      <= '0;
			tag_s2      <= '0;
			x_on_q      <= 1'b0;
			xr_q        <= '0;
			xc_q        <= '0;
			xv_s1       <= 1'b0;
			xr_s1       <= '0;
			xc_s1       <= '0;
			dr_q        <= '0;
			div_busy_q  <= 1'b0;
			cnt_q       <= '0;
			holds_q     <= 1'b0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
			end
		end else begin
			// issue blend reads, element outer, influence inner
			if (issue_on_q) begin
				tag_s1.valid  <= 1'b1;
				tag_s1.first  <= (ik_q == 2'd0);
				tag_s1.last   <= (ik_q == job_q.last_inf);
				tag_s1.elem   <= ie_q;
				tag_s1.weight <= job_q.weights[ik_q];
				if (ik_q == job_q.last_inf) begin
					ik_q <= '0;
					ie_q <= ie_q + 4'd1;
					if (ie_q == 4'd15) issue_on_q <= 1'b0;
				end else begin
					ik_q <= ik_q + 2'd1;
				end
			end else begin
				tag_s1 <= '0;
			end
			tag_s2 <= tag_s1;

			// issue transform products, row outer, column inner
			xv_s1 <= x_on_q;
			xr_s1 <= xr_q;
			xc_s1 <= xc_q;
			if (x_on_q) begin
				xc_q <= xc_q + 2'd1;
				if (xc_q == 2'd3) begin
					xr_q <= xr_q + 2'd1;
					if (xr_q == 2'd3) x_on_q <= 1'b0;
				end
			end

			// post a new result, or drop a taken one
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (boxes.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop_fire) begin
						fault_q <= 1'b0;
						unique case (job.kind)
							KIND_VERTEX: begin
								issue_on_q <= 1'b1;
								ie_q       <= '0;
								ik_q       <= '0;
								state_q    <= ST_BLEND;
							end
							KIND_CLEAR: begin
								holds_q <= 1'b0;
								for (int i = 0; i < 3; i++) begin
									min_q[i] <= '0;
									max_q[i] <= '0;
								end
								state_q <= ST_EMIT;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_BLEND: begin
					if (tag_s2.valid && tag_s2.last && tag_s2.elem == 4'd15) begin
						x_on_q  <= 1'b1;
						xr_q    <= '0;
						xc_q    <= '0;
						state_q <= ST_XFORM;
					end
				end
				ST_XFORM: begin
					if (xv_s1 && xc_s1 == 2'd3 && xr_s1 == 2'd3) begin
						dr_q       <= '0;
						div_busy_q <= 1'b0;
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy_q) begin
						if (t_q[3] == '0) begin
							fault_q <= 1'b1;
							state_q <= ST_EMIT;
						end else if (ovf) begin
							if (dr_q == 2'd2) state_q <= ST_BOX;
							dr_q <= dr_q + 2'd1;
						end else begin
							div_busy_q <= 1'b1;
							cnt_q      <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
						if (div_done) begin
							div_busy_q <= 1'b0;
							if (dr_q == 2'd2) state_q <= ST_BOX;
							dr_q <= dr_q + 2'd1;
						end
					end
				end
				ST_BOX: begin
					holds_q <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (!holds_q || q_q[i] < min_q[i]) min_q[i] <= q_q[i];
						if (!holds_q || q_q[i] > max_q[i]) max_q[i] <= q_q[i];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop_fire) job_q <= job;

		// blend multiply and accumulate
		prod_s2 <= rd_s1 * $signed({1'b0, tag_s1.weight});
		if (tag_s2.valid) begin
			acc_q <= acc_new;
			if (tag_s2.last) blend_q[tag_s2.elem] <= sat36(acc_rnd[51:16]);
		end

		// transform multiply and row sum
		mul_s1 <= blend_q[{xc_q, xr_q}] * coord;
		if (xv_s1) begin
			tacc_q <= tsum;
			if (xc_s1 == 2'd3) t_q[xr_s1] <= tsum;
		end

		// restoring division, one quotient bit per cycle
		if (div_start) begin
			rem_q <= {15'd0, a_abs[57:15]};
			low_q <= {a_abs[14:0], 16'd0};
			quo_q <= '0;
			if (ovf) q_q[dr_q] <= neg ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (div_busy_q) begin
			rem_q <= qbit ? 58'(rem2 - {1'b0, d_abs}) : rem2[57:0];
			low_q <= {low_q[29:0], 1'b0};
			quo_q <= quo_next;
			if (div_done) q_q[dr_q] <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
		end

		// capture the result
		if (emit_fire) begin
			for (int i = 0; i < 3; i++) begin
				out_min_q[i] <= min_q[i];
				out_max_q[i] <= max_q[i];
			end
			out_empty_q <= !holds_q;
			out_fault_q <= fault_q;
		end
	end

	assign boxes.valid        = out_valid_q;
	assign boxes.box_min_x    = out_min_q[0];
	assign boxes.box_min_y    = out_min_q[1];
	assign boxes.box_min_z    = out_min_q[2];
	assign boxes.box_max_x    = out_max_q[0];
	assign boxes.box_max_y    = out_max_q[1];
	assign boxes.box_max_z    = out_max_q[2];
	assign boxes.box_empty    = out_empty_q;
	assign boxes.divide_fault = out_fault_q;

	`SVBB_ASSERT_IMPLY(a_box_order, holds_q, (min_q[0] <= max_q[0]) && (min_q[1] <= max_q[1]) && (min_q[2] <= max_q[2]), "box min above max")
	`SVBB_ASSERT_IMPLY(a_empty_zero, !holds_q, (min_q[0] == 0) && (max_q[0] == 0) && (min_q[1] == 0) && (max_q[1] == 0) && (min_q[2] == 0) && (max_q[2] == 0), "empty box not zero")
	`SVBB_ASSERT_IMPLY(a_blend_drained, state_q == ST_XFORM, !issue_on_q && !tag_s1.valid && !tag_s2.valid, "blend pipeline busy in transform")
	`SVBB_ASSERT_NEXT(a_emit_done, emit_fire, out_valid_q && (state_q == ST_IDLE), "result not posted")

endmodule

// File: rtl/skinned_vertex_bounding_box.sv
// Top level of the skinned vertex bounding box.
// Channels: items (load matrix word, process vertex, clear box), cfg (influence
// count write, taken at once), boxes (one running box per item). All use
// valid/ready; a transfer happens when both are high on a rising clk edge.
// Items pass a decode stage into a two-entry queue, so the sender keeps going
// while the back end works. The back end handles one item at a time.
// Load, clear and unknown items go from the queue through the emit state to the
// result register. A vertex is blended (n = influences, one store read and one
// multiply per cycle), transformed on one 32x32 multiplier, divided (one
// quotient bit per cycle, up to three quotients), then updates the box and its
// result is posted.
// The result register holds its box until taken; a stalled receiver holds the
// back end, then the queue fills and items.ready drops.
// Reset (arst_n low) empties the box, zeroes min and max, sets the influence
// count to 4 and drops all valids; the matrix store keeps no reset value.
module skinned_vertex_bounding_box #(
	parameter int MAX_BONES      = 256,
	parameter int MAX_INFLUENCES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	svbb_in_if.sink   items,
	svbb_cfg_if.sink  cfg,
	svbb_out_if.source boxes
);
	import svbb_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	// Decode and classify
	svbb_front #(
		.MAX_BONES     (MAX_BONES),
		.MAX_INFLUENCES(MAX_INFLUENCES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Decouple front and back
	svbb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// Execute and report
	svbb_back #(
		.MAX_BONES(MAX_BONES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job_ready(pop_ready),
		.job      (pop_data),
		.boxes    (boxes)
	);

endmodule
